>>> rtl/aging_edge_distance_table_unit_defines.svh
// ----------------------------------------------------------------------------
// aging edge distance table: assertion macros
// shared property wrappers for the checks at the end of the top level
// ----------------------------------------------------------------------------
`ifndef AGING_EDGE_DISTANCE_TABLE_UNIT_DEFINES_SVH
`define AGING_EDGE_DISTANCE_TABLE_UNIT_DEFINES_SVH

// same-cycle implication
`define AEDT_ASSERT_IMPLY(label, clock, resetn, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!(resetn)) (ante) |-> (cons)) \
        else $error("aedt same-cycle check failed");

// next-cycle implication
`define AEDT_ASSERT_NEXT(label, clock, resetn, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!(resetn)) (ante) |=> (cons)) \
        else $error("aedt next-cycle check failed");

`endif

>>> rtl/aedt_pkg.sv
// ----------------------------------------------------------------------------
// aedt_pkg
// types, codes and helpers for the aging edge distance table
// ----------------------------------------------------------------------------
package aedt_pkg;

    localparam int MAX_ENTRIES_DEF = 20;
    // cell position field, enough for the largest table of 32 entries
    localparam int POS_W = 5;

    localparam logic [19:0] STALE_RST  = 20'd20000;
    localparam logic [8:0]  WEIGHT_RST = 9'd90;
    localparam logic [15:0] MIN_RST    = 16'd102;
    localparam logic [15:0] MAX_RST    = 16'd10240;
    localparam logic [8:0]  WEIGHT_FULL = 9'd256;

    localparam logic [1:0] CMD_UPDATE = 2'd0;
    localparam logic [1:0] CMD_EXPIRE = 2'd1;
    localparam logic [1:0] CMD_READ   = 2'd2;
    localparam logic [1:0] CMD_CLEAR  = 2'd3;

    localparam logic [2:0] ST_UPDATED  = 3'd0;
    localparam logic [2:0] ST_INSERTED = 3'd1;
    localparam logic [2:0] ST_BAD_IDS  = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_RANGE    = 3'd4;

    localparam logic [1:0] REG_STALE  = 2'd0;
    localparam logic [1:0] REG_WEIGHT = 2'd1;
    localparam logic [1:0] REG_MIN    = 2'd2;
    localparam logic [1:0] REG_MAX    = 2'd3;

    typedef struct packed {
        logic [31:0] low_id;
        logic [31:0] high_id;
        logic [15:0] distance;
        logic [31:0] seen;
    } entry_t;

    typedef struct packed {
        logic             shift;
        logic             feed;
        logic             load;
        logic [POS_W-1:0] pos;
    } cell_ctrl_t;

    function automatic logic [15:0] clip_distance(input logic [15:0] d,
                                                  input logic [15:0] lo,
                                                  input logic [15:0] hi);
        logic [15:0] r;
        if (d < lo)
        begin
            r = lo;
        end
        else if (d > hi)
        begin
            r = hi;
        end
        else
        begin
            r = d;
        end
        return r;
    endfunction

endpackage

>>> rtl/aedt_cell.sv
// ----------------------------------------------------------------------------
// aedt_cell
// one table slot; shifts towards the head, takes the recirculated word at
// the ring tail or a new entry when loaded
// ----------------------------------------------------------------------------
module aedt_cell
    import aedt_pkg::*;
#(
    parameter int IDX = 0
)
(
    input  logic       clk,
    input  cell_ctrl_t ctrl,
    input  entry_t     from_next,
    input  entry_t     from_head,
    input  entry_t     new_entry,
    output entry_t     entry
);

    entry_t entry_reg;
    entry_t entry_next;
    logic   at_pos;

    assign at_pos = (ctrl.pos == POS_W'(IDX));

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.load && at_pos)
        begin
            entry_next = new_entry;
        end
        else if (ctrl.shift)
        begin
            if (ctrl.feed && at_pos)
            begin
                entry_next = from_head;
            end
            else
            begin
                entry_next = from_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

>>> rtl/aedt_head.sv
// ----------------------------------------------------------------------------
// aedt_head
// work on the entry at the head of the ring: key match, age check and
// weighted average of the distance
// ----------------------------------------------------------------------------
module aedt_head
    import aedt_pkg::*;
(
    input  entry_t      head,
    input  logic [31:0] key_low,
    input  logic [31:0] key_high,
    input  logic [15:0] sample_dist,
    input  logic [8:0]  weight,
    input  logic [31:0] time_now,
    input  logic [19:0] stale_limit,
    output logic        match,
    output logic        fresh,
    output logic [15:0] blended
);

    logic [31:0] age;
    logic [8:0]  w_sat;
    logic [8:0]  w_inv;
    logic [24:0] p_old;
    logic [24:0] p_new;
    logic [24:0] sum;

    assign match = (head.low_id == key_low) && (head.high_id == key_high);

    // wrapping age
    assign age   = time_now - head.seen;
    assign fresh = (age <= {12'd0, stale_limit});

    assign w_sat = (weight > WEIGHT_FULL) ? WEIGHT_FULL : weight;
    assign w_inv = WEIGHT_FULL - w_sat;
    assign p_old = {9'd0, head.distance} * {16'd0, w_inv};
    assign p_new = {9'd0, sample_dist} * {16'd0, w_sat};
    // round half up
    assign sum     = p_old + p_new + 25'd128;
    assign blended = sum[23:8];

endmodule

>>> rtl/aging_edge_distance_table_unit.sv
// ----------------------------------------------------------------------------
// aging_edge_distance_table_unit
// link table held in a ring of cells rotating past a head unit
// ----------------------------------------------------------------------------
// flow: update, expire and read scan the count entries past the head unit, then report
//   from the done state, count being the valid entries at accept; bad ids, clear and
//   out of range go straight to the done state; one command at a time, the ring moving
//   one entry per cycle past the head unit while scanning; done waits for m_tready
// reset: entry count cleared, registers to defaults, slot contents left as they are
`include "aging_edge_distance_table_unit_defines.svh"

module aging_edge_distance_table_unit
    import aedt_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    // command(2) first_id(32) second_id(32) distance_in(16) time_now(32)
    // entry_index(5), lowest bit first, one zero pad bit on top
    input  logic [119:0] s_tdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    // status(3) entry_low_id(32) entry_high_id(32) entry_distance(16)
    // entry_count(6), lowest bit first, zero pad on top
    output logic [95:0]  m_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

    typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DONE} state_t;

    state_t      state_reg;
    logic [19:0] stale_reg;
    logic [8:0]  weight_reg;
    logic [15:0] min_reg;
    logic [15:0] max_reg;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] total_reg;
    logic [CNT_W-1:0] len_reg;
    logic [CNT_W-1:0] k_reg;
    logic             found_reg;
    logic [1:0]       cmd_reg;
    logic [31:0]      klo_reg;
    logic [31:0]      khi_reg;
    logic [15:0]      dist_reg;
    logic [31:0]      now_reg;
    logic [4:0]       idx_reg;

    logic [2:0]  res_status_reg;
    logic [31:0] res_lo_reg;
    logic [31:0] res_hi_reg;
    logic [15:0] res_dist_reg;
    logic [95:0] m_tdata_reg;
    logic        m_tvalid_reg;

    // input word fields
    logic [1:0]  in_cmd;
    logic [31:0] in_a;
    logic [31:0] in_b;
    logic [15:0] in_dist;
    logic [31:0] in_now;
    logic [4:0]  in_idx;

    entry_t     ent [MAX_ENTRIES];
    entry_t     head;
    entry_t     fb_entry;
    entry_t     new_entry;
    cell_ctrl_t ctrl;
    logic       match;
    logic       fresh;
    logic [15:0] blended;
    logic       scan_active;
    logic       hit;
    logic       cfg_wr;

    assign in_cmd  = s_tdata[1:0];
    assign in_a    = s_tdata[33:2];
    assign in_b    = s_tdata[65:34];
    assign in_dist = s_tdata[81:66];
    assign in_now  = s_tdata[113:82];
    assign in_idx  = s_tdata[118:114];

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tdata  = m_tdata_reg;
    assign m_tvalid = m_tvalid_reg;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        case (paddr[3:2])
            REG_STALE:  prdata = {12'd0, stale_reg};
            REG_WEIGHT: prdata = {23'd0, weight_reg};
            REG_MIN:    prdata = {16'd0, min_reg};
            REG_MAX:    prdata = {16'd0, max_reg};
            default:    prdata = 32'd0;
        endcase
    end

    // ring of cells, cell 0 is the head
    assign head = ent[0];

    aedt_head u_head (
        .head        (head),
        .key_low     (klo_reg),
        .key_high    (khi_reg),
        .sample_dist (dist_reg),
        .weight      (weight_reg),
        .time_now    (now_reg),
        .stale_limit (stale_reg),
        .match       (match),
        .fresh       (fresh),
        .blended     (blended)
    );

    assign scan_active = (state_reg == ST_SCAN) && (k_reg != total_reg);
    assign hit         = (cmd_reg == CMD_UPDATE) && match && !found_reg;
    assign new_entry   = '{low_id: klo_reg, high_id: khi_reg, distance: dist_reg,
                           seen: now_reg};

    always_comb
    begin
        fb_entry = head;
        if (hit)
        begin
            fb_entry.distance = blended;
            fb_entry.seen     = now_reg;
        end
        ctrl.shift = scan_active;
        // stale entries are not fed back, so the ring shrinks past them
        ctrl.feed  = scan_active && ((cmd_reg != CMD_EXPIRE) || fresh);
        ctrl.load  = (state_reg == ST_SCAN) && (k_reg == total_reg)
                     && (cmd_reg == CMD_UPDATE) && !found_reg
                     && (count_reg < CNT_W'(MAX_ENTRIES));
        if (ctrl.load)
        begin
            ctrl.pos = POS_W'(count_reg);
        end
        else
        begin
            ctrl.pos = POS_W'(len_reg - CNT_W'(1));
        end
    end

    for (genvar i = 0; i < MAX_ENTRIES; i++)
    begin : g_cell
        entry_t nxt;
        if (i == MAX_ENTRIES - 1)
        begin : g_last
            assign nxt = ent[i];
        end
        else
        begin : g_mid
            assign nxt = ent[i+1];
        end
        aedt_cell #(.IDX(i)) u_cell (
            .clk       (clk),
            .ctrl      (ctrl),
            .from_next (nxt),
            .from_head (fb_entry),
            .new_entry (new_entry),
            .entry     (ent[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            stale_reg      <= STALE_RST;
            weight_reg     <= WEIGHT_RST;
            min_reg        <= MIN_RST;
            max_reg        <= MAX_RST;
            count_reg      <= '0;
            total_reg      <= '0;
            len_reg        <= '0;
            k_reg          <= '0;
            found_reg      <= 1'b0;
            cmd_reg        <= CMD_UPDATE;
            m_tvalid_reg   <= 1'b0;
            res_status_reg <= ST_UPDATED;
        end
        else
        begin
            if (cfg_wr)
            begin
                case (paddr[3:2])
                    REG_STALE:  stale_reg  <= pwdata[19:0];
                    REG_WEIGHT: weight_reg <= pwdata[8:0];
                    REG_MIN:    min_reg    <= pwdata[15:0];
                    REG_MAX:    max_reg    <= pwdata[15:0];
                    default:    ;
                endcase
            end

            // the done state reloads the output register itself
            if (m_tvalid_reg && m_tready && (state_reg != ST_DONE))
            begin
                m_tvalid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        cmd_reg        <= in_cmd;
                        now_reg        <= in_now;
                        idx_reg        <= in_idx;
                        k_reg          <= '0;
                        total_reg      <= count_reg;
                        len_reg        <= count_reg;
                        found_reg      <= 1'b0;
                        res_lo_reg     <= '0;
                        res_hi_reg     <= '0;
                        res_dist_reg   <= '0;
                        case (in_cmd)
                            CMD_UPDATE:
                            begin
                                if (in_a == '0 || in_b == '0 || in_a == in_b)
                                begin
                                    res_status_reg <= ST_BAD_IDS;
                                    state_reg      <= ST_DONE;
                                end
                                else
                                begin
                                    res_status_reg <= ST_UPDATED;
                                    klo_reg   <= (in_a < in_b) ? in_a : in_b;
                                    khi_reg   <= (in_a < in_b) ? in_b : in_a;
                                    dist_reg  <= clip_distance(in_dist, min_reg, max_reg);
                                    state_reg <= ST_SCAN;
                                end
                            end
                            CMD_EXPIRE:
                            begin
                                res_status_reg <= ST_UPDATED;
                                state_reg      <= ST_SCAN;
                            end
                            CMD_READ:
                            begin
                                if ({1'b0, in_idx} >= 6'(count_reg))
                                begin
                                    res_status_reg <= ST_RANGE;
                                    state_reg      <= ST_DONE;
                                end
                                else
                                begin
                                    res_status_reg <= ST_UPDATED;
                                    state_reg      <= ST_SCAN;
                                end
                            end
                            default:
                            begin
                                res_status_reg <= ST_UPDATED;
                                count_reg      <= '0;
                                state_reg      <= ST_DONE;
                            end
                        endcase
                    end
                end

                ST_SCAN:
                begin
                    if (scan_active)
                    begin
                        k_reg <= k_reg + CNT_W'(1);
                        case (cmd_reg)
                            CMD_UPDATE:
                            begin
                                if (hit)
                                begin
                                    found_reg    <= 1'b1;
                                    res_dist_reg <= blended;
                                end
                            end
                            CMD_EXPIRE:
                            begin
                                if (!fresh)
                                begin
                                    len_reg <= len_reg - CNT_W'(1);
                                end
                            end
                            CMD_READ:
                            begin
                                if (6'(k_reg) == {1'b0, idx_reg})
                                begin
                                    res_lo_reg   <= head.low_id;
                                    res_hi_reg   <= head.high_id;
                                    res_dist_reg <= head.distance;
                                end
                            end
                            default: ;
                        endcase
                    end
                    else
                    begin
                        case (cmd_reg)
                            CMD_UPDATE:
                            begin
                                if (found_reg)
                                begin
                                    res_status_reg <= ST_UPDATED;
                                    res_lo_reg     <= klo_reg;
                                    res_hi_reg     <= khi_reg;
                                end
                                else if (ctrl.load)
                                begin
                                    res_status_reg <= ST_INSERTED;
                                    res_lo_reg     <= klo_reg;
                                    res_hi_reg     <= khi_reg;
                                    res_dist_reg   <= dist_reg;
                                    count_reg      <= count_reg + CNT_W'(1);
                                end
                                else
                                begin
                                    res_status_reg <= ST_FULL;
                                end
                            end
                            CMD_EXPIRE:
                            begin
                                count_reg <= len_reg;
                            end
                            default: ;
                        endcase
                        state_reg <= ST_DONE;
                    end
                end

                ST_DONE:
                begin
                    if (!m_tvalid_reg || m_tready)
                    begin
                        m_tdata_reg  <= {7'd0, 6'(count_reg), res_dist_reg,
                                         res_hi_reg, res_lo_reg, res_status_reg};
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    `AEDT_ASSERT_IMPLY(a_count_range, clk, rst_n, 1'b1, count_reg <= CNT_W'(MAX_ENTRIES))
    `AEDT_ASSERT_IMPLY(a_scan_bounds, clk, rst_n, state_reg == ST_SCAN, (k_reg <= total_reg) && (len_reg <= total_reg))
    `AEDT_ASSERT_NEXT(a_clear_empties, clk, rst_n, s_tvalid && s_tready && (s_tdata[1:0] == CMD_CLEAR), count_reg == '0)
    `AEDT_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, s_tvalid && s_tready, !s_tready)

endmodule

>>> test/tb_aging_edge_distance_table_unit.sv
// ----------------------------------------------------------------------------
// tb_aging_edge_distance_table_unit
// self-checking bench for the link table: commands stream in with random
// gaps, every result word is checked against a behavioural copy of the table,
// and the clamp, average and stale limit registers are swept between phases
// ----------------------------------------------------------------------------
module tb_aging_edge_distance_table_unit;
    import aedt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_DEPTH    = MAX_ENTRIES_DEF;
    localparam int PHASES         = 6;
    localparam int PHASE_ITEMS    = 258;
    localparam int ID_POOL        = 8;
    localparam int SETTLE_CYCLES  = 32;
    localparam int WATCHDOG_LIMIT = 3000;

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] first_id;
        logic [31:0] second_id;
        logic [15:0] distance_in;
        logic [31:0] time_now;
        logic [4:0]  entry_index;
    } link_cmd_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] low_id;
        logic [31:0] high_id;
        logic [15:0] distance;
        logic [5:0]  count;
    } link_result_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    // command, first_id, second_id, distance_in, time_now, entry_index, pad
    logic [119:0] s_tdata = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    // status, entry_low_id, entry_high_id, entry_distance, entry_count, pad
    logic [95:0]  m_tdata;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [3:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;

    // expected-side copy of the table and its registers
    logic [31:0] tbl_low  [TABLE_DEPTH];
    logic [31:0] tbl_high [TABLE_DEPTH];
    logic [15:0] tbl_dist [TABLE_DEPTH];
    logic [31:0] tbl_seen [TABLE_DEPTH];
    int unsigned tbl_used = 0;
    logic [19:0] cfg_stale  = STALE_RST;
    logic [8:0]  cfg_weight = WEIGHT_RST;
    logic [15:0] cfg_min    = MIN_RST;
    logic [15:0] cfg_max    = MAX_RST;

    link_cmd_t    pending_cmds[$];
    link_result_t awaited_results[$];
    link_cmd_t    cur_cmd;
    link_result_t seen_word;
    link_result_t want_word;
    int unsigned  send_idle_pct = 17;
    int unsigned  recv_stall_pct = 64;
    int unsigned  mismatch_count = 0;
    int unsigned  stuck_cycles = 0;

    aging_edge_distance_table_unit #(
        .MAX_ENTRIES(TABLE_DEPTH)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    function automatic link_result_t apply_link_command(input link_cmd_t c);
        link_result_t r;
        logic [31:0]  key_lo;
        logic [31:0]  key_hi;
        logic [15:0]  d;
        int           found;
        int unsigned  w;
        int unsigned  sum;
        int unsigned  kept;
        int unsigned  i;
        r = '0;
        r.status = ST_UPDATED;
        case (c.command)
            CMD_UPDATE:
            begin
                if (c.first_id == 0 || c.second_id == 0 || c.first_id == c.second_id)
                begin
                    r.status = ST_BAD_IDS;
                end
                else
                begin
                    key_lo = (c.first_id < c.second_id) ? c.first_id : c.second_id;
                    key_hi = (c.first_id < c.second_id) ? c.second_id : c.first_id;
                    // when the two bounds cross, values below min take min and all others take max
                    if (c.distance_in < cfg_min)
                    begin
                        d = cfg_min;
                    end
                    else if (c.distance_in > cfg_max)
                    begin
                        d = cfg_max;
                    end
                    else
                    begin
                        d = c.distance_in;
                    end
                    found = -1;
                    for (i = 0; i < tbl_used; i++)
                    begin
                        if (found < 0 && tbl_low[i] == key_lo && tbl_high[i] == key_hi)
                        begin
                            found = i;
                        end
                    end
                    if (found >= 0)
                    begin
                        w = (cfg_weight > WEIGHT_FULL) ? 256 : cfg_weight;
                        sum = tbl_dist[found] * (256 - w) + d * w + 128;
                        tbl_dist[found] = sum[23:8];
                        tbl_seen[found] = c.time_now;
                        r.low_id = key_lo;
                        r.high_id = key_hi;
                        r.distance = tbl_dist[found];
                    end
                    else if (tbl_used >= TABLE_DEPTH)
                    begin
                        r.status = ST_FULL;
                    end
                    else
                    begin
                        tbl_low[tbl_used] = key_lo;
                        tbl_high[tbl_used] = key_hi;
                        tbl_dist[tbl_used] = d;
                        tbl_seen[tbl_used] = c.time_now;
                        tbl_used++;
                        r.status = ST_INSERTED;
                        r.low_id = key_lo;
                        r.high_id = key_hi;
                        r.distance = d;
                    end
                end
            end
            CMD_EXPIRE:
            begin
                // age is taken modulo 2^32, survivors slide down in order
                kept = 0;
                for (i = 0; i < tbl_used; i++)
                begin
                    if (c.time_now - tbl_seen[i] <= cfg_stale)
                    begin
                        tbl_low[kept] = tbl_low[i];
                        tbl_high[kept] = tbl_high[i];
                        tbl_dist[kept] = tbl_dist[i];
                        tbl_seen[kept] = tbl_seen[i];
                        kept++;
                    end
                end
                tbl_used = kept;
            end
            CMD_READ:
            begin
                if (c.entry_index < tbl_used)
                begin
                    r.low_id = tbl_low[c.entry_index];
                    r.high_id = tbl_high[c.entry_index];
                    r.distance = tbl_dist[c.entry_index];
                end
                else
                begin
                    r.status = ST_RANGE;
                end
            end
            default:
            begin
                tbl_used = 0;
            end
        endcase
        r.count = tbl_used[5:0];
        return r;
    endfunction

    // driver: one word offered at a time, held until taken
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                awaited_results.push_back(apply_link_command(cur_cmd));
            end
            if (!s_tvalid || s_tready)
            begin
                if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    cur_cmd = pending_cmds.pop_front();
                    s_tdata <= {1'b0, cur_cmd.entry_index, cur_cmd.time_now,
                                cur_cmd.distance_in, cur_cmd.second_id,
                                cur_cmd.first_id, cur_cmd.command};
                    s_tvalid <= 1'b1;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor: compare each result word with the oldest expectation
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                seen_word.status   = m_tdata[2:0];
                seen_word.low_id   = m_tdata[34:3];
                seen_word.high_id  = m_tdata[66:35];
                seen_word.distance = m_tdata[82:67];
                seen_word.count    = m_tdata[88:83];
                if (awaited_results.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t ns: unexpected word, expected none, got status %0d",
                             $time, seen_word.status);
                    $display("%0t ns: actual ids %h/%h dist %h count %0d",
                             $time, seen_word.low_id, seen_word.high_id,
                             seen_word.distance, seen_word.count);
                end
                else
                begin
                    want_word = awaited_results.pop_front();
                    if (seen_word !== want_word)
                    begin
                        mismatch_count++;
                        $display("%0t ns: expected status %0d ids %h/%h dist %h count %0d",
                                 $time, want_word.status, want_word.low_id,
                                 want_word.high_id, want_word.distance, want_word.count);
                        $display("%0t ns: actual   status %0d ids %h/%h dist %h count %0d",
                                 $time, seen_word.status, seen_word.low_id,
                                 seen_word.high_id, seen_word.distance, seen_word.count);
                    end
                end
            end
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // watchdog on cycles in which neither side nor the register port moves
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
            begin
                stuck_cycles <= 0;
            end
            else
            begin
                stuck_cycles <= stuck_cycles + 1;
            end
            if (stuck_cycles >= WATCHDOG_LIMIT)
            begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    task automatic queue_cmd(input logic [1:0] command, input logic [31:0] first_id,
                             input logic [31:0] second_id, input logic [15:0] distance_in,
                             input logic [31:0] time_now, input logic [4:0] entry_index);
        pending_cmds.push_back('{command: command, first_id: first_id, second_id: second_id,
                                 distance_in: distance_in, time_now: time_now,
                                 entry_index: entry_index});
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [31:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {index, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (index)
            REG_STALE:  cfg_stale = value[19:0];
            REG_WEIGHT: cfg_weight = value[8:0];
            REG_MIN:    cfg_min = value[15:0];
            default:    cfg_max = value[15:0];
        endcase
    endtask

    task automatic wait_until_drained();
        while (pending_cmds.size() != 0 || s_tvalid || awaited_results.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    logic [19:0] stale_set  [PHASES] = '{20'd20000, 20'd0, 20'hFFFFF, 20'd3000, 20'd700, 20'd0};
    logic [8:0]  weight_set [PHASES] = '{9'd90, 9'd256, 9'd0, 9'd128, 9'd1, 9'd0};
    logic [15:0] min_set    [PHASES] = '{16'd102, 16'd0, 16'hFFFF, 16'd300, 16'd2000, 16'd0};
    logic [15:0] max_set    [PHASES] = '{16'd10240, 16'hFFFF, 16'd0, 16'd40000, 16'd1500, 16'd0};

    initial
    begin
        logic [31:0] id_pool [ID_POOL];
        logic [31:0] clock_ms;
        logic [31:0] ida;
        logic [31:0] idb;
        logic [15:0] dist_val;
        int unsigned step;
        int unsigned roll;
        int unsigned sub;
        int          phase;
        int          n;
        int          k;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: empty table, bad ids, clamps, average, wrapping expiry, clear
        queue_cmd(CMD_READ,   0, 0, 0, 0, 0);
        queue_cmd(CMD_EXPIRE, 0, 0, 0, 0, 0);
        queue_cmd(CMD_UPDATE, 0, 5, 16'd500, 0, 0);
        queue_cmd(CMD_UPDATE, 7, 0, 16'd500, 0, 0);
        queue_cmd(CMD_UPDATE, 9, 9, 16'd500, 0, 0);
        queue_cmd(CMD_UPDATE, 32'hFFFF_FFFF, 1, 16'd0, 32'd1000, 0);
        queue_cmd(CMD_UPDATE, 1, 32'hFFFF_FFFF, 16'hFFFF, 32'd1000, 5'd31);
        queue_cmd(CMD_UPDATE, 100, 50, 16'd5000, 32'd25000, 0);
        queue_cmd(CMD_READ,   0, 0, 0, 0, 5'd1);
        queue_cmd(CMD_READ,   0, 0, 0, 0, 5'd31);
        queue_cmd(CMD_READ,   0, 0, 0, 0, 5'd2);
        queue_cmd(CMD_EXPIRE, 0, 0, 0, 32'd25500, 0);
        queue_cmd(CMD_READ,   0, 0, 0, 0, 5'd0);
        queue_cmd(CMD_UPDATE, 3, 4, 16'd20000, 32'hFFFF_FF00, 0);
        queue_cmd(CMD_EXPIRE, 0, 0, 0, 32'h0000_0100, 0);
        queue_cmd(CMD_UPDATE, 5, 6, 16'd50, 32'h0000_0200, 0);
        // one entry sits exactly at the stale limit and must survive
        queue_cmd(CMD_EXPIRE, 0, 0, 0, 32'h0000_0200 + 32'd20000, 0);
        queue_cmd(CMD_READ,   0, 0, 0, 0, 5'd0);
        queue_cmd(CMD_UPDATE, 6, 5, 16'd10240, 32'h0000_5000, 0);
        queue_cmd(CMD_CLEAR,  0, 0, 0, 0, 0);
        queue_cmd(CMD_READ,   0, 0, 0, 0, 5'd0);
        wait_until_drained();

        clock_ms = $urandom;
        for (phase = 0; phase < PHASES; phase++)
        begin
            if (phase < 2)
            begin
                send_idle_pct = 17;
                recv_stall_pct = 64;
            end
            else if (phase < 4)
            begin
                send_idle_pct = 64;
                recv_stall_pct = 17;
            end
            else
            begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
            end
            if (phase != 0)
            begin
                if (phase == PHASES - 1)
                begin
                    stale_set[phase] = 20'($urandom_range(0, 20'hFFFFF));
                    weight_set[phase] = 9'($urandom_range(0, 256));
                    min_set[phase] = 16'($urandom_range(0, 16'hFFFF));
                    max_set[phase] = 16'($urandom_range(0, 16'hFFFF));
                end
                write_reg(REG_STALE, stale_set[phase]);
                write_reg(REG_WEIGHT, weight_set[phase]);
                write_reg(REG_MIN, min_set[phase]);
                write_reg(REG_MAX, max_set[phase]);
                @(negedge clk);
            end
            // time steps scaled to the limit so entries both age out and survive
            step = (cfg_stale >> 3) + 2;
            for (k = 0; k < ID_POOL; k++)
            begin
                id_pool[k] = $urandom;
                if (id_pool[k] == 0)
                begin
                    id_pool[k] = 1;
                end
            end
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                if ($urandom_range(0, 2) != 0)
                begin
                    clock_ms = clock_ms + $urandom_range(0, step);
                end
                if ($urandom_range(0, 99) < 3)
                begin
                    clock_ms = $urandom;
                end
                ida = id_pool[$urandom_range(0, ID_POOL - 1)];
                idb = id_pool[$urandom_range(0, ID_POOL - 1)];
                case ($urandom_range(0, 9))
                    0:       dist_val = 16'h0000;
                    1:       dist_val = 16'hFFFF;
                    2:       dist_val = cfg_min;
                    3:       dist_val = cfg_max;
                    default: dist_val = 16'($urandom);
                endcase
                roll = $urandom_range(0, 99);
                if (roll < 60)
                begin
                    sub = $urandom_range(0, 99);
                    if (sub < 4)
                    begin
                        ida = 0;
                    end
                    else if (sub < 6)
                    begin
                        idb = 0;
                    end
                    else if (sub < 10)
                    begin
                        idb = ida;
                    end
                    else if (sub < 16)
                    begin
                        ida = $urandom;
                    end
                    queue_cmd(CMD_UPDATE, ida, idb, dist_val, clock_ms, 5'($urandom));
                end
                else if (roll < 72)
                begin
                    queue_cmd(CMD_EXPIRE, ida, idb, dist_val, clock_ms, 5'($urandom));
                end
                else if (roll < 98)
                begin
                    queue_cmd(CMD_READ, ida, idb, dist_val, clock_ms,
                              5'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 31)
                                                             : $urandom_range(0, TABLE_DEPTH)));
                end
                else
                begin
                    queue_cmd(CMD_CLEAR, ida, idb, dist_val, clock_ms, 5'($urandom));
                end
            end
            wait_until_drained();
        end

        if (mismatch_count == 0 && awaited_results.size() == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

>>> files.f
+incdir+rtl
rtl/aedt_pkg.sv
rtl/aedt_cell.sv
rtl/aedt_head.sv
rtl/aging_edge_distance_table_unit.sv
test/tb_aging_edge_distance_table_unit.sv
